[sv/assert_macros.svh]
// Assertion macros used by the RGB to HSL converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define ASSERT_DELAYED(lbl, clk, rst, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("delayed check failed");

`endif

[sv/rhc_pkg.sv]
// Package for the RGB to HSL converter: constants, sector codes, divider chain word.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  localparam int COMP_W           = 8;
  localparam int QUO_W            = 10;          // hue quotient reaches 960
  localparam int DIV_W            = 18;          // 960 * 255 fits in 18 bits
  localparam int HUE_W            = 13;
  localparam int NUM_CELLS        = QUO_W;       // one quotient bit per cell
  localparam int COMP_MAX         = 255;
  localparam int HUE_SCALE        = 960;
  localparam int HUE_GREEN_OFFSET = 1920;
  localparam int HUE_BLUE_OFFSET  = 3840;
  localparam int HUE_FULL_TURN    = 5760;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Word handed from cell to cell: two divisions in flight plus side data.
  typedef struct packed {
    logic [DIV_W-1:0]  hue_rem;
    logic [DIV_W-1:0]  hue_div;
    logic [QUO_W-1:0]  hue_quo;
    logic [DIV_W-1:0]  sat_rem;
    logic [DIV_W-1:0]  sat_div;
    logic [QUO_W-1:0]  sat_quo;
    logic              hue_neg;
    sector_t           sector;
    logic [COMP_W-1:0] lightness;
    logic              grey;
  } chain_t;

endpackage

`default_nettype wire

[sv/rhc_prep.sv]
// Front end: max/min, sector, sum and delta, then divider operands.
`timescale 1ns / 1ps
`default_nettype none

module rhc_prep (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [7:0]               red,
  input  wire logic [7:0]               green,
  input  wire logic [7:0]               blue,
  output logic                          out_valid,
  output rhc_pkg::chain_t               out_data
);
  import rhc_pkg::*;

  // Stage 1 combinational: extremes and sector
  logic [COMP_W-1:0] mx, mn;
  sector_t           sector;
  logic [COMP_W:0]   diff;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    if (red >= green && red >= blue) begin
      sector = SECT_RED;
    end else if (green >= blue) begin
      sector = SECT_GREEN;
    end else begin
      sector = SECT_BLUE;
    end
    case (sector)
      SECT_RED:   diff = {1'b0, green} - {1'b0, blue};
      SECT_GREEN: diff = {1'b0, blue} - {1'b0, red};
      default:    diff = {1'b0, red} - {1'b0, green};
    endcase
  end

  // Stage 1 registers
  logic              s1_valid;
  sector_t           s1_sector;
  logic [COMP_W:0]   s1_diff;
  logic [COMP_W:0]   s1_sum;
  logic [COMP_W-1:0] s1_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_sector <= sector;
    s1_diff   <= diff;
    s1_sum    <= {1'b0, mx} + {1'b0, mn};
    s1_delta  <= mx - mn;
  end

  // Stage 2 combinational: numerators and pre-shifted divisors
  logic [COMP_W:0]   neg_diff;
  logic [COMP_W-1:0] abs_diff;
  logic [COMP_W:0]   sat_den;
  chain_t            prep;

  always_comb begin
    neg_diff = -s1_diff;
    abs_diff = s1_diff[COMP_W] ? neg_diff[COMP_W-1:0] : s1_diff[COMP_W-1:0];
    if (s1_sum <= (COMP_W+1)'(COMP_MAX)) begin
      sat_den = s1_sum;
    end else begin
      sat_den = (COMP_W+1)'(2 * COMP_MAX) - s1_sum;
    end
    prep.hue_rem   = DIV_W'(abs_diff) * DIV_W'(HUE_SCALE);
    prep.hue_div   = DIV_W'(s1_delta) << (QUO_W - 1);
    prep.hue_quo   = '0;
    prep.sat_rem   = DIV_W'(s1_delta) * DIV_W'(COMP_MAX);
    prep.sat_div   = DIV_W'(sat_den) << (QUO_W - 1);
    prep.sat_quo   = '0;
    prep.hue_neg   = s1_diff[COMP_W];
    prep.sector    = s1_sector;
    prep.lightness = s1_sum[COMP_W:1];
    prep.grey      = (s1_delta == '0);
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    out_data <= prep;
  end

endmodule

`default_nettype wire

[sv/rhc_cell.sv]
// Divider cell: one restoring step for the hue and saturation quotients.
`timescale 1ns / 1ps
`default_nettype none

module rhc_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire rhc_pkg::chain_t in_data,
  output logic                 out_valid,
  output rhc_pkg::chain_t      out_data
);
  import rhc_pkg::*;

  logic   hue_ge, sat_ge;
  chain_t step;

  // Subtract the shifted divisor when it fits, shift in the quotient bit
  always_comb begin
    hue_ge        = (in_data.hue_rem >= in_data.hue_div);
    sat_ge        = (in_data.sat_rem >= in_data.sat_div);
    step          = in_data;
    step.hue_rem  = hue_ge ? in_data.hue_rem - in_data.hue_div : in_data.hue_rem;
    step.sat_rem  = sat_ge ? in_data.sat_rem - in_data.sat_div : in_data.sat_rem;
    step.hue_div  = in_data.hue_div >> 1;
    step.sat_div  = in_data.sat_div >> 1;
    step.hue_quo  = {in_data.hue_quo[QUO_W-2:0], hue_ge};
    step.sat_quo  = {in_data.sat_quo[QUO_W-2:0], sat_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= step;
  end

endmodule

`default_nettype wire

[sv/rgb_to_hsl_convert.sv]
// RGB to HSL converter top level: front end, divider cell chain, output stage.
// Pipeline from the accepting edge to the done strobe: 2 front-end stages, 10 divider
// cells, 1 output register; one quotient bit per cell.
// Throughput: one pixel per clock; busy is always low and results are never held.
// Reset (rst, synchronous, active high) clears every valid bit in the pipeline;
// transactions in flight at reset are dropped.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_convert (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic             done,
  output logic [12:0]      hue,
  output logic [7:0]       lightness,
  output logic [7:0]       saturation,
  output logic             hue_undefined
);
  import rhc_pkg::*;
  `include "assert_macros.svh"

  localparam int LATENCY = NUM_CELLS + 3;
  localparam int HW      = HUE_W + 1;   // one extra bit for the sign

  // Pipeline never stalls
  assign busy = 1'b0;

  logic   cell_valid [0:NUM_CELLS];
  chain_t cell_data  [0:NUM_CELLS];

  rhc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (cell_valid[0]),
    .out_data  (cell_data[0])
  );

  // Divider chain
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[i]),
      .in_data   (cell_data[i]),
      .out_valid (cell_valid[i+1]),
      .out_data  (cell_data[i+1])
    );
  end

  // Hue: apply sector offset, floor for negative differences, wrap
  chain_t             last;
  logic [QUO_W:0]     hue_mag;
  logic [HW-1:0]      hue_off;
  logic [HW-1:0]      hue_raw;
  logic [HW-1:0]      hue_wrap;

  always_comb begin
    last    = cell_data[NUM_CELLS];
    hue_mag = {1'b0, last.hue_quo} + (QUO_W+1)'(last.hue_rem != '0);
    case (last.sector)
      SECT_RED:   hue_off = '0;
      SECT_GREEN: hue_off = HW'(HUE_GREEN_OFFSET);
      default:    hue_off = HW'(HUE_BLUE_OFFSET);
    endcase
    if (last.hue_neg) begin
      hue_raw = hue_off - HW'(hue_mag);
    end else begin
      hue_raw = hue_off + HW'(last.hue_quo);
    end
    hue_wrap = hue_raw[HW-1] ? hue_raw + HW'(HUE_FULL_TURN) : hue_raw;
  end

  // Output register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cell_valid[NUM_CELLS];
    end
    lightness     <= last.lightness;
    hue_undefined <= last.grey;
    hue           <= last.grey ? '0 : hue_wrap[HUE_W-1:0];
    saturation    <= last.grey ? '0 : last.sat_quo[COMP_W-1:0];
  end

  // Checks
  `ASSERT_DELAYED(a_fixed_latency, clk, rst, start && !busy, LATENCY, done)
  `ASSERT_IMPLIES(a_grey_zero, clk, rst, done && hue_undefined, hue == '0 && saturation == '0)
  `ASSERT_IMPLIES(a_hue_range, clk, rst, done, hue < 13'(HUE_FULL_TURN))

endmodule

`default_nettype wire

[verif/tb_rgb_to_hsl_convert.sv]
// Testbench for rgb_to_hsl_convert: directed pixel table plus random pixels, checked in order.
`timescale 1ns / 1ps

module tb_rgb_to_hsl_convert;
  import rhc_pkg::*;

  // Expected conversion of one pixel
  typedef struct packed {
    logic [12:0] hue;
    logic [7:0]  lightness;
    logic [7:0]  saturation;
    logic        undef;
  } hsl_pixel_t;

  // One row of the directed table; want is only used when known is set
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       known;
    hsl_pixel_t want;
  } pixel_row_t;

  localparam int N_DIRECTED     = 21;
  localparam int N_RANDOM       = 1100;
  localparam int WATCHDOG_LIMIT = 400;   // well above the longest idle gap plus the pipeline latency
  localparam int DRAIN_CYCLES   = 20;

  localparam pixel_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // grey pixels: hue has no meaning
    '{8'd0,   8'd0,   8'd0,   1'b1, '{13'd0,    8'd0,   8'd0,   1'b1}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{13'd0,    8'd255, 8'd0,   1'b1}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{13'd0,    8'd128, 8'd0,   1'b1}},
    // primaries and secondaries at full scale
    '{8'd255, 8'd0,   8'd0,   1'b1, '{13'd0,    8'd127, 8'd255, 1'b0}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{13'd1920, 8'd127, 8'd255, 1'b0}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{13'd3840, 8'd127, 8'd255, 1'b0}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{13'd960,  8'd127, 8'd255, 1'b0}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{13'd2880, 8'd127, 8'd255, 1'b0}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{13'd4800, 8'd127, 8'd255, 1'b0}},
    // smallest nonzero delta at both ends of the lightness range
    '{8'd1,   8'd0,   8'd0,   1'b1, '{13'd0,    8'd0,   8'd255, 1'b0}},
    '{8'd255, 8'd254, 8'd254, 1'b1, '{13'd0,    8'd254, 8'd255, 1'b0}},
    // negative hue wraps around the full turn
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd200, 8'd10,  8'd11,  1'b0, '0},
    // ties for the maximum: earlier component wins
    '{8'd200, 8'd200, 8'd100, 1'b0, '0},
    '{8'd100, 8'd200, 8'd200, 1'b0, '0},
    '{8'd200, 8'd100, 8'd200, 1'b0, '0},
    // saturation branch boundary around sum = 255
    '{8'd128, 8'd127, 8'd127, 1'b0, '0},
    '{8'd129, 8'd127, 8'd128, 1'b0, '0},
    // alternating bit patterns and small values
    '{8'd170, 8'd85,  8'd85,  1'b0, '0},
    '{8'd1,   8'd2,   8'd3,   1'b0, '0},
    '{8'd254, 8'd1,   8'd127, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  red = 8'd0;
  logic [7:0]  green = 8'd0;
  logic [7:0]  blue = 8'd0;
  logic        done;
  logic [12:0] hue;
  logic [7:0]  lightness;
  logic [7:0]  saturation;
  logic        hue_undefined;

  // typed expectation that rides along with the pixel on the inputs
  logic        use_typed = 1'b0;
  hsl_pixel_t  typed_want = '0;

  hsl_pixel_t  pending_hsl [$];
  hsl_pixel_t  oldest;
  int          pixels_accepted = 0;
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          progress;

  rgb_to_hsl_convert DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .done         (done),
    .hue          (hue),
    .lightness    (lightness),
    .saturation   (saturation),
    .hue_undefined(hue_undefined)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Quotient rounded toward minus infinity; den is always positive
  function automatic int floor_quotient(input int num, input int den);
    int q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // HLS conversion of one pixel
  function automatic hsl_pixel_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    int ri, gi, bi, mx, mn, sum, delta, hue_val, sat;
    sector_t sect;
    hsl_pixel_t res;
    ri = r;
    gi = g;
    bi = b;
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    sum = mx + mn;
    delta = mx - mn;
    hue_val = 0;
    sat = 0;
    if (delta != 0) begin
      if (sum <= COMP_MAX) sat = (COMP_MAX * delta) / sum;
      else sat = (COMP_MAX * delta) / (2 * COMP_MAX - sum);
      // first component equal to the maximum picks the sector
      if (ri == mx) sect = SECT_RED;
      else if (gi == mx) sect = SECT_GREEN;
      else sect = SECT_BLUE;
      case (sect)
        SECT_RED: begin
          hue_val = floor_quotient(HUE_SCALE * (gi - bi), delta);
        end
        SECT_GREEN: begin
          hue_val = HUE_GREEN_OFFSET + floor_quotient(HUE_SCALE * (bi - ri), delta);
        end
        default: begin
          hue_val = HUE_BLUE_OFFSET + floor_quotient(HUE_SCALE * (ri - gi), delta);
        end
      endcase
      if (hue_val < 0) hue_val = hue_val + HUE_FULL_TURN;
    end
    res.hue = hue_val[12:0];
    res.lightness = sum[8:1];
    res.saturation = sat[7:0];
    res.undef = (delta == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want_val);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want_val);
    error_count++;
  endtask

  // Monitor: record accepted pixels, check results in order, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      progress = 1'b0;
      if (done) begin
        progress = 1'b1;
        if (pending_hsl.size() == 0) begin
          report_mismatch("result with no pixel pending, hue", hue, 0);
        end else begin
          oldest = pending_hsl.pop_front();
          if (hue !== oldest.hue) report_mismatch("hue", hue, oldest.hue);
          if (lightness !== oldest.lightness)
            report_mismatch("lightness", lightness, oldest.lightness);
          if (saturation !== oldest.saturation)
            report_mismatch("saturation", saturation, oldest.saturation);
          if (hue_undefined !== oldest.undef)
            report_mismatch("hue_undefined", hue_undefined, oldest.undef);
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        pending_hsl.push_back(use_typed ? typed_want : convert_pixel(red, green, blue));
        pixels_accepted++;
      end
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Present one pixel at a falling edge, return at the falling edge after acceptance
  task automatic drive_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic known, input hsl_pixel_t want);
    int seen;
    seen = pixels_accepted;
    start <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    use_typed <= known;
    typed_want <= want;
    do @(negedge clk); while (pixels_accepted == seen);
  endtask

  // Random idle gap: mostly none, some short, a few long; garbage on the data lines
  task automatic idle_gap(inout int burst_left);
    int roll, gap;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (roll < 3) begin
      burst_left = $urandom_range(30, 80);
      gap = 0;
    end else if (roll < 60) gap = 0;
    else if (roll < 93) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      red <= 8'($urandom);
      green <= 8'($urandom);
      blue <= 8'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stimulus
  initial begin
    int burst_left, mode, k;
    logic [7:0] comp [3];
    logic [7:0] swap;
    burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      drive_pixel(DIRECTED_ROWS[i].r, DIRECTED_ROWS[i].g, DIRECTED_ROWS[i].b,
                  DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);
      idle_gap(burst_left);
    end

    // random pixels, weighted toward the corners of the conversion
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      case (mode)
        4: begin
          // grey
          comp[0] = 8'($urandom);
          comp[1] = comp[0];
          comp[2] = comp[0];
        end
        5: begin
          // nearly grey, small delta
          comp[0] = 8'($urandom_range(0, 252));
          comp[1] = 8'(comp[0] + $urandom_range(0, 3));
          comp[2] = 8'(comp[0] + $urandom_range(0, 3));
          comp[0] = 8'(comp[0] + $urandom_range(0, 3));
        end
        6: begin
          // two components tie for the maximum
          comp[0] = 8'($urandom_range(1, 255));
          comp[1] = comp[0];
          comp[2] = 8'($urandom_range(0, comp[0] - 1));
        end
        7: begin
          // values at the ends of the range
          for (int j = 0; j < 3; j++) begin
            case ($urandom_range(0, 3))
              0: comp[j] = 8'd0;
              1: comp[j] = 8'd1;
              2: comp[j] = 8'd254;
              default: comp[j] = 8'd255;
            endcase
          end
        end
        8: begin
          // max + min right at the saturation branch point
          comp[0] = 8'($urandom_range(128, 255));
          comp[2] = 8'(8'd255 - comp[0] + $urandom_range(0, 1));
          comp[1] = 8'($urandom_range(comp[2], comp[0]));
        end
        default: begin
          comp[0] = 8'($urandom);
          comp[1] = 8'($urandom);
          comp[2] = 8'($urandom);
        end
      endcase
      // scatter the components over red, green, blue
      k = $urandom_range(0, 2);
      if ($urandom_range(0, 1) == 1) begin
        swap = comp[1];
        comp[1] = comp[2];
        comp[2] = swap;
      end
      drive_pixel(comp[k], comp[(k + 1) % 3], comp[(k + 2) % 3], 1'b0, '0);
      idle_gap(burst_left);
    end

    // drain
    start <= 1'b0;
    while (pending_hsl.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
